>>> sv/wbs_pkg.sv
// Shared constants, register indexes and the CORDIC angle table of the bearing steering block.
package wbs_pkg;

    // Default sizes handed to the top level parameters.
    localparam int COORD_BITS_DEF    = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fixed field widths.
    localparam int HDG_W    = 16;
    localparam int ANG_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_LIMIT = 1'b1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET      = 16'd4096;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 15'd4096;

    // Angles: the CORDIC runs at radians * 65536, results are radians * 8192.
    localparam int Z_W         = 20;
    localparam int PI_Q16      = 205887;
    localparam int TWO_PI_Q16  = 411775;
    localparam int PI_Q13      = 25736;
    localparam int TWO_PI_Q13  = 51472;
    localparam int STEER_MAX   = 25736;

    // Heading conversion: (deg128 * 205887 + 180 * 512) / (180 * 1024).
    // The divisor is 4096 * 45; the shift is free and 45 becomes a reciprocal
    // multiply that is exact for every 22-bit quotient.
    localparam int DEG_HALF_TURN   = 180;
    localparam int DEG_TO_RAD_MUL  = 205887;
    localparam int HALF_TURN_ROUND = DEG_HALF_TURN * 512;
    localparam int DIV_SHIFT       = 12;
    localparam int DIV_REST        = DEG_HALF_TURN * 1024 / 4096;
    localparam int PROD_W          = 34;
    localparam int QUOT_W          = PROD_W - DIV_SHIFT;
    localparam int RECIP_SHIFT     = 28;
    localparam longint RECIP_MUL   = ((64'd1 << RECIP_SHIFT) + DIV_REST - 1) / DIV_REST;
    localparam int HRAD_W          = 17;
    localparam int RECIP_W         = RECIP_SHIFT + HRAD_W;

    // Error and gain path.
    localparam int ERR_W    = HRAD_W + 1;
    localparam int MAG_W    = HRAD_W;
    localparam int GPROD_W  = GAIN_W + MAG_W;
    localparam int GAIN_FRAC = 12;
    localparam int GAINED_W = GPROD_W + 1 - GAIN_FRAC;

    // atan(2^-i) * 65536, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            0:       v = 20'sd51472;
            1:       v = 20'sd30386;
            2:       v = 20'sd16055;
            3:       v = 20'sd8150;
            4:       v = 20'sd4091;
            5:       v = 20'sd2047;
            6:       v = 20'sd1024;
            7:       v = 20'sd512;
            8:       v = 20'sd256;
            9:       v = 20'sd128;
            10:      v = 20'sd64;
            11:      v = 20'sd32;
            12:      v = 20'sd16;
            13:      v = 20'sd8;
            14:      v = 20'sd4;
            15:      v = 20'sd2;
            16:      v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/wbs_cordic_stage.sv
// One registered vectoring micro-rotation of the CORDIC atan2 chain.
module wbs_cordic_stage
    import wbs_pkg::*;
#(
    parameter int XW  = COORD_BITS_DEF + 4,
    parameter int IDX = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  logic signed [Z_W-1:0] in_z,
    input  logic                 in_zero,
    output logic                 out_valid,
    output logic signed [XW-1:0] out_x,
    output logic signed [XW-1:0] out_y,
    output logic signed [Z_W-1:0] out_z,
    output logic                 out_zero
);

    logic signed [XW-1:0]  xs, ys, x_next, y_next;
    logic signed [Z_W-1:0] z_next, angle;
    logic                  valid_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic signed [Z_W-1:0] z_reg;
    logic                  zero_reg;

    assign xs    = in_x >>> IDX;
    assign ys    = in_y >>> IDX;
    assign angle = atan_q16(IDX);

    // Positive y turns clockwise, anything else counterclockwise.
    always_comb begin
        if (in_y > 0) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + angle;
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= in_zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_zero  = zero_reg;

endmodule

>>> sv/wbs_heading.sv
// Heading conversion from degrees * 128 to radians * 8192, delayed to meet the bearing.
module wbs_heading
    import wbs_pkg::*;
#(
    parameter int LAT = CORDIC_STAGES_DEF + 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [HDG_W-1:0]  heading_deg,
    output logic [HRAD_W-1:0] hrad
);

    localparam int DEPTH = LAT - 2;

    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;
    logic [HRAD_W-1:0]  hrad_reg [0:DEPTH-1];

    assign prod_next = PROD_W'(heading_deg) * PROD_W'(DEG_TO_RAD_MUL)
                     + PROD_W'(HALF_TURN_ROUND);
    // Floor division by 45 as a multiply by the rounded-up reciprocal.
    assign recip_next = RECIP_W'(prod_reg[PROD_W-1:DIV_SHIFT]) * RECIP_W'(RECIP_MUL);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= prod_next;
            recip_reg   <= recip_next;
            hrad_reg[0] <= recip_reg[RECIP_SHIFT +: HRAD_W];
            for (int i = 1; i < DEPTH; i++) begin
                hrad_reg[i] <= hrad_reg[i-1];
            end
        end
    end

    assign hrad = hrad_reg[DEPTH-1];

endmodule

>>> sv/wbs_steer.sv
// Bearing wrap and rounding, heading error, proportional gain and output clamp stages.
module wbs_steer
    import wbs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [Z_W-1:0]    in_z,
    input  logic                     in_zero,
    input  logic [HRAD_W-1:0]        in_hrad,
    input  logic [GAIN_W-1:0]        gain,
    input  logic [LIMIT_W-1:0]       limit,
    output logic                     out_valid,
    output logic signed [ANG_W-1:0]  steer_angle,
    output logic [ANG_W-1:0]         bearing,
    output logic                     turn_left,
    output logic                     limited
);

    // Bearing stage.
    logic signed [Z_W-1:0] z_wrap, z_round;
    logic [ANG_W-1:0]      brg_raw, brg_next;
    logic                  f_valid_reg;
    logic [ANG_W-1:0]      f_brg_reg;
    logic [HRAD_W-1:0]     f_hrad_reg;

    // Error stage.
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        err_abs;
    logic                    left_next;
    logic                    e_valid_reg, e_left_reg;
    logic [MAG_W-1:0]        e_mag_reg;
    logic [ANG_W-1:0]        e_brg_reg;

    // Gain stage.
    logic                    g_valid_reg, g_left_reg, g_over_reg;
    logic [GPROD_W-1:0]      g_prod_reg;
    logic [ANG_W-1:0]        g_brg_reg;

    // Output stage.
    logic [GPROD_W:0]        gained_sum;
    logic [GAINED_W-1:0]     pick, mag;
    logic                    cap;
    logic                    valid_reg, left_reg, limited_reg;
    logic signed [ANG_W-1:0] steer_reg;
    logic [ANG_W-1:0]        brg_reg;

    assign z_wrap  = (in_z < 0) ? in_z + Z_W'(TWO_PI_Q16) : in_z;
    assign z_round = z_wrap + Z_W'(4);
    assign brg_raw = z_round[Z_W-2:3];
    assign brg_next = (in_zero || brg_raw >= ANG_W'(TWO_PI_Q13)) ? '0 : brg_raw;

    assign err     = $signed({1'b0, f_hrad_reg}) - $signed({2'b0, f_brg_reg});
    assign err_abs = (err < 0) ? ERR_W'(-err) : ERR_W'(err);

    // A positive error turns left only at half a turn or more; zero counts as left.
    always_comb begin
        if (err > 0) begin
            left_next = (err >= ERR_W'(PI_Q13));
        end else begin
            left_next = (err_abs < ERR_W'(PI_Q13));
        end
    end

    assign gained_sum = {1'b0, g_prod_reg} + (GPROD_W + 1)'(2048);

    always_comb begin
        pick = g_over_reg ? GAINED_W'(limit) : gained_sum[GPROD_W:GAIN_FRAC];
        cap  = g_over_reg;
        mag  = pick;
        if (pick > GAINED_W'(STEER_MAX)) begin
            mag = GAINED_W'(STEER_MAX);
            cap = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else if (en) begin
            f_valid_reg <= in_valid;
            e_valid_reg <= f_valid_reg;
            g_valid_reg <= e_valid_reg;
            valid_reg   <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_brg_reg   <= brg_next;
            f_hrad_reg  <= in_hrad;
            e_mag_reg   <= err_abs[MAG_W-1:0];
            e_left_reg  <= left_next;
            e_brg_reg   <= f_brg_reg;
            g_prod_reg  <= GPROD_W'(gain) * GPROD_W'(e_mag_reg);
            g_over_reg  <= (e_mag_reg > MAG_W'(limit));
            g_left_reg  <= e_left_reg;
            g_brg_reg   <= e_brg_reg;
            steer_reg   <= g_left_reg ? -ANG_W'(mag) : ANG_W'(mag);
            left_reg    <= g_left_reg;
            limited_reg <= cap;
            brg_reg     <= g_brg_reg;
        end
    end

    assign out_valid   = valid_reg;
    assign steer_angle = steer_reg;
    assign bearing     = brg_reg;
    assign turn_left   = left_reg;
    assign limited     = limited_reg;

    a_steer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (steer_reg <= ANG_W'(STEER_MAX)) && (steer_reg >= -ANG_W'(STEER_MAX)))
        else $error("steering command outside its range");

    a_bearing_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (brg_reg < ANG_W'(TWO_PI_Q13)))
        else $error("bearing not wrapped below two pi");

    a_sign_matches_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (left_reg ? (steer_reg <= 0) : (steer_reg >= 0)))
        else $error("steering sign disagrees with turn direction");

endmodule

>>> sv/waypoint_bearing_steering.sv
// Top level of the waypoint bearing and proportional steering pipeline.
//
// The input channel (s_valid/s_ready) takes one beat per position set: car and
// waypoint coordinates plus the car heading in degrees * 128. Each beat yields
// exactly one result beat on the m_ channel with the steering command, the
// bearing to the waypoint (radians * 8192, counterclockwise from east), the
// turn direction and a flag that tells whether the command was capped. The
// user writes gain and limit on cfg_ only with no beat in flight; unchecked.
//
// The datapath is a single pipeline of CORDIC_STAGES + 5 register stages:
// one stage forms the coordinate differences, one CORDIC micro-rotation per
// stage follows, and four stages wrap the bearing, form the heading error,
// apply the gain and clamp. A new beat is taken every cycle unless the result
// side stalls: when the receiver holds m_ready low with a result waiting,
// the whole pipeline freezes and s_ready drops in the same cycle, so nothing
// is lost or repeated. A synchronous active-low reset empties the pipeline
// and returns gain and limit to 4096; payload registers are not reset.
module waypoint_bearing_steering
    import wbs_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_car_x,
    input  logic signed [COORD_BITS-1:0] s_car_y,
    input  logic signed [COORD_BITS-1:0] s_goal_x,
    input  logic signed [COORD_BITS-1:0] s_goal_y,
    input  logic [HDG_W-1:0]             s_heading_deg,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [ANG_W-1:0]      m_steer_angle,
    output logic [ANG_W-1:0]             m_bearing,
    output logic                         m_turn_left,
    output logic                         m_limited
);

    // Differences need one extra bit; the CORDIC gain and the first
    // rotation grow the vector by less than a factor of four.
    localparam int DW = COORD_BITS + 1;
    localparam int XW = COORD_BITS + 4;

    logic                  adv;
    logic [GAIN_W-1:0]     gain_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic signed [DW-1:0]  dx_fwd, dy_fwd, dx_rev, dy_rev;
    logic signed [XW-1:0]  x_next, y_next;
    logic signed [Z_W-1:0] z_next;
    logic                  zero_next;

    logic                  c_valid [0:CORDIC_STAGES];
    logic signed [XW-1:0]  c_x     [0:CORDIC_STAGES];
    logic signed [XW-1:0]  c_y     [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] c_z     [0:CORDIC_STAGES];
    logic                  c_zero  [0:CORDIC_STAGES];

    logic                  prep_valid_reg;
    logic signed [XW-1:0]  prep_x_reg, prep_y_reg;
    logic signed [Z_W-1:0] prep_z_reg;
    logic                  prep_zero_reg;

    logic [HRAD_W-1:0]     hrad;

    // The pipeline moves whenever the output slot is empty or being taken.
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STEER_GAIN:  gain_reg  <= cfg_wdata;
                REG_STEER_LIMIT: limit_reg <= cfg_wdata[LIMIT_W-1:0];
            endcase
        end
    end

    // Both difference directions are formed in parallel, so a waypoint to the
    // west is turned by pi without a negation after the subtraction.
    assign dx_fwd    = DW'(s_goal_x) - DW'(s_car_x);
    assign dy_fwd    = DW'(s_goal_y) - DW'(s_car_y);
    assign dx_rev    = DW'(s_car_x) - DW'(s_goal_x);
    assign dy_rev    = DW'(s_car_y) - DW'(s_goal_y);
    assign x_next    = dx_fwd[DW-1] ? XW'(dx_rev) : XW'(dx_fwd);
    assign y_next    = dx_fwd[DW-1] ? XW'(dy_rev) : XW'(dy_fwd);
    assign z_next    = dx_fwd[DW-1] ? Z_W'(PI_Q16) : '0;
    assign zero_next = (dx_fwd == '0) && (dy_fwd == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (adv) begin
            prep_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prep_x_reg    <= x_next;
            prep_y_reg    <= y_next;
            prep_z_reg    <= z_next;
            prep_zero_reg <= zero_next;
        end
    end

    assign c_valid[0] = prep_valid_reg;
    assign c_x[0]     = prep_x_reg;
    assign c_y[0]     = prep_y_reg;
    assign c_z[0]     = prep_z_reg;
    assign c_zero[0]  = prep_zero_reg;

    // One micro-rotation per register stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        wbs_cordic_stage #(
            .XW  (XW),
            .IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (c_valid[i]),
            .in_x      (c_x[i]),
            .in_y      (c_y[i]),
            .in_z      (c_z[i]),
            .in_zero   (c_zero[i]),
            .out_valid (c_valid[i+1]),
            .out_x     (c_x[i+1]),
            .out_y     (c_y[i+1]),
            .out_z     (c_z[i+1]),
            .out_zero  (c_zero[i+1])
        );
    end

    // The heading path has the same depth as the preparation and CORDIC stages.
    wbs_heading #(
        .LAT (CORDIC_STAGES + 1)
    ) u_heading (
        .aclk        (aclk),
        .en          (adv),
        .heading_deg (s_heading_deg),
        .hrad        (hrad)
    );

    wbs_steer u_steer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (c_valid[CORDIC_STAGES]),
        .in_z        (c_z[CORDIC_STAGES]),
        .in_zero     (c_zero[CORDIC_STAGES]),
        .in_hrad     (hrad),
        .gain        (gain_reg),
        .limit       (limit_reg),
        .out_valid   (m_valid),
        .steer_angle (m_steer_angle),
        .bearing     (m_bearing),
        .turn_left   (m_turn_left),
        .limited     (m_limited)
    );

endmodule

>>> test/wbs_steer_checker.sv
// Checker for the bearing steering block: predicts each result and compares it with the m_ beat.
module wbs_steer_checker
    import wbs_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_car_x,
    input  logic signed [COORD_BITS-1:0] s_car_y,
    input  logic signed [COORD_BITS-1:0] s_goal_x,
    input  logic signed [COORD_BITS-1:0] s_goal_y,
    input  logic [HDG_W-1:0]             s_heading_deg,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [ANG_W-1:0]      m_steer_angle,
    input  logic [ANG_W-1:0]             m_bearing,
    input  logic                         m_turn_left,
    input  logic                         m_limited,
    output int                           fail_count,
    output int                           in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint HALF_TURN_Q16 = 205887;
    localparam longint FULL_TURN_Q16 = 411775;
    localparam longint HALF_TURN_Q13 = 25736;
    localparam longint FULL_TURN_Q13 = 51472;
    localparam longint STEER_CAP     = 25736;
    localparam longint DEG_PER_HALF  = 180;
    localparam int     PRINT_CAP     = 60;

    typedef struct packed {
        logic signed [ANG_W-1:0] steer;
        logic [ANG_W-1:0]        bearing;
        logic                    turn_left;
        logic                    limited;
    } steer_result_t;

    steer_result_t        expected_q[$];
    steer_result_t        want;
    logic [GAIN_W-1:0]    gain_q;
    logic [LIMIT_W-1:0]   limit_q;
    int                   mismatch_count = 0;
    int                   result_no = 0;

    assign fail_count = mismatch_count;

    // Rotation angle of one CORDIC micro-step, radians * 65536.
    function automatic longint micro_angle(input int stage);
        case (stage)
            0:  return 51472;
            1:  return 30386;
            2:  return 16055;
            3:  return 8150;
            4:  return 4091;
            5:  return 2047;
            6:  return 1024;
            7:  return 512;
            8:  return 256;
            9:  return 128;
            10: return 64;
            11: return 32;
            12: return 16;
            13: return 8;
            14: return 4;
            15: return 2;
            16: return 1;
            default: return 0;
        endcase
    endfunction

    // Vectoring atan2 of (dx, dy), wrapped into [0, 2pi) at radians * 8192.
    function automatic longint bearing_of(input longint dx, input longint dy);
        longint x, y, z, xs, ys, b;
        int     i;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx;
        y = dy;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN_Q16;
        end
        for (i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + micro_angle(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - micro_angle(i);
            end
        end
        while (z < 0)
            z = z + FULL_TURN_Q16;
        while (z >= FULL_TURN_Q16)
            z = z - FULL_TURN_Q16;
        b = (z + 4) >>> 3;
        if (b >= FULL_TURN_Q13)
            b = b - FULL_TURN_Q13;
        return b;
    endfunction

    function automatic steer_result_t predict_steering(
        input logic signed [COORD_BITS-1:0] cx,
        input logic signed [COORD_BITS-1:0] cy,
        input logic signed [COORD_BITS-1:0] gx,
        input logic signed [COORD_BITS-1:0] gy,
        input logic [HDG_W-1:0]             hdg,
        input logic [GAIN_W-1:0]            gain,
        input logic [LIMIT_W-1:0]           limit
    );
        steer_result_t r;
        longint        brg, hrad, err, err_mag, mag, steer;
        logic          left, capped;
        brg  = bearing_of(longint'(gx) - longint'(cx), longint'(gy) - longint'(cy));
        hrad = (longint'(hdg) * HALF_TURN_Q16 + DEG_PER_HALF * 512) / (DEG_PER_HALF * 1024);
        err  = hrad - brg;
        err_mag = (err < 0) ? -err : err;
        // A positive error turns right unless it is half a turn or more.
        if (err > 0)
            left = !(err < HALF_TURN_Q13);
        else
            left = (err_mag < HALF_TURN_Q13);
        capped = 1'b0;
        if (err_mag > longint'(limit)) begin
            mag    = longint'(limit);
            capped = 1'b1;
        end else begin
            mag = (longint'(gain) * err_mag + 2048) >>> 12;
        end
        if (mag > STEER_CAP) begin
            mag    = STEER_CAP;
            capped = 1'b1;
        end
        steer = left ? -mag : mag;
        r.steer     = steer[ANG_W-1:0];
        r.bearing   = brg[ANG_W-1:0];
        r.turn_left = left;
        r.limited   = capped;
        return r;
    endfunction

    // Printing stops after a while so that a broken block does not flood the log.
    task automatic report_mismatch(input string what, input longint got, input longint want_v);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns result %0d: %s got %0d expected %0d",
                     $time, result_no, what, got, want_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_q  = GAIN_RESET;
            limit_q = LIMIT_RESET;
            expected_q.delete();
            in_flight <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_STEER_GAIN:  gain_q  = cfg_wdata[GAIN_W-1:0];
                    REG_STEER_LIMIT: limit_q = cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected, bearing", m_bearing, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_steer_angle !== want.steer)
                        report_mismatch("steer_angle", m_steer_angle, want.steer);
                    if (m_bearing !== want.bearing)
                        report_mismatch("bearing", m_bearing, want.bearing);
                    if (m_turn_left !== want.turn_left)
                        report_mismatch("turn_left", m_turn_left, want.turn_left);
                    if (m_limited !== want.limited)
                        report_mismatch("limited", m_limited, want.limited);
                end
                result_no++;
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict_steering(s_car_x, s_car_y, s_goal_x, s_goal_y,
                                                      s_heading_deg, gain_q, limit_q));
            in_flight <= expected_q.size();
        end
    end

endmodule

>>> test/tb_waypoint_bearing_steering.sv
// Testbench top: drives position sets and register writes into the steering block and gives the verdict.
module tb_waypoint_bearing_steering;
    timeunit 1ns;
    timeprecision 1ps;

    import wbs_pkg::*;

    localparam int CB           = COORD_BITS_DEF;
    // Depth of the block's pipeline in register stages.
    localparam int PIPE_LATENCY = CORDIC_STAGES_DEF + 5;
    localparam int PHASE_ITEMS  = 140;
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_CYCLES  = 200;
    // A correct run never goes quiet for longer than the long hold-off plus
    // the pipeline depth; the limit leaves a wide margin above that.
    localparam int STALL_LIMIT  = 4000;
    localparam int HDG_FULL     = 46080;

    localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_STEER_GAIN;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [CB-1:0]    s_car_x = '0;
    logic signed [CB-1:0]    s_car_y = '0;
    logic signed [CB-1:0]    s_goal_x = '0;
    logic signed [CB-1:0]    s_goal_y = '0;
    logic [HDG_W-1:0]        s_heading_deg = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [ANG_W-1:0] m_steer_angle;
    logic [ANG_W-1:0]        m_bearing;
    logic                    m_turn_left;
    logic                    m_limited;

    int   fail_count;
    int   in_flight;

    // Idle rates in percent, changed by the stimulus between phases.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    // Raised once by the stimulus; the result side then stops taking beats for a while.
    logic backpressure_req = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    waypoint_bearing_steering uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_car_x       (s_car_x),
        .s_car_y       (s_car_y),
        .s_goal_x      (s_goal_x),
        .s_goal_y      (s_goal_y),
        .s_heading_deg (s_heading_deg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_steer_angle (m_steer_angle),
        .m_bearing     (m_bearing),
        .m_turn_left   (m_turn_left),
        .m_limited     (m_limited)
    );

    wbs_steer_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_car_x       (s_car_x),
        .s_car_y       (s_car_y),
        .s_goal_x      (s_goal_x),
        .s_goal_y      (s_goal_y),
        .s_heading_deg (s_heading_deg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_steer_angle (m_steer_angle),
        .m_bearing     (m_bearing),
        .m_turn_left   (m_turn_left),
        .m_limited     (m_limited),
        .fail_count    (fail_count),
        .in_flight     (in_flight)
    );

    // A coordinate: mostly anything in range, sometimes an extreme or a value near zero.
    function automatic logic signed [CB-1:0] pick_coord();
        int d;
        case ($urandom_range(7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: begin
                d = int'($urandom_range(64)) - 32;
                return CB'(d);
            end
            default: return CB'($urandom);
        endcase
    endfunction

    // Offers one beat, with random idle cycles ahead of it, and returns at the
    // edge where it is taken. Valid and payload hold still until then.
    task automatic offer_item(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
                              input logic signed [CB-1:0] gx, input logic signed [CB-1:0] gy,
                              input logic [HDG_W-1:0] hdg);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_car_x       <= cx;
        s_car_y       <= cy;
        s_goal_x      <= gx;
        s_goal_y      <= gy;
        s_heading_deg <= hdg;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Random geometry: coincident points, axis-aligned offsets, short vectors
    // where the CORDIC resolution matters, and long vectors anywhere.
    task automatic offer_random_item();
        logic signed [CB-1:0] cx, cy, gx, gy;
        logic [HDG_W-1:0]     hdg;
        int                   dx, dy;
        cx = pick_coord();
        cy = pick_coord();
        dx = int'($urandom_range(512)) - 256;
        dy = int'($urandom_range(512)) - 256;
        case ($urandom_range(9))
            0: begin
                gx = cx;
                gy = cy;
            end
            1: begin
                gx = cx;
                gy = pick_coord();
            end
            2: begin
                gx = pick_coord();
                gy = cy;
            end
            3, 4: begin
                gx = cx + CB'(dx);
                gy = cy + CB'(dy);
            end
            default: begin
                gx = pick_coord();
                gy = pick_coord();
            end
        endcase
        // Now and then a heading beyond a full turn, which the block converts without a wrap.
        if ($urandom_range(4) == 0)
            hdg = HDG_W'($urandom);
        else
            hdg = HDG_W'($urandom_range(HDG_FULL));
        offer_item(cx, cy, gx, gy, hdg);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0)
            @(posedge aclk);
    endtask

    // Writes gain and then limit on back-to-back edges, only while the block is empty.
    task automatic program_steering(input logic [GAIN_W-1:0] gain,
                                    input logic [LIMIT_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEER_GAIN;
        cfg_wdata <= gain;
        @(posedge aclk);
        cfg_index <= REG_STEER_LIMIT;
        cfg_wdata <= {1'b0, limit};
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls at the rate of the current phase, plus one
    // long hold-off while the sender keeps pushing so that the pipeline fills
    // and s_ready drops.
    initial begin : result_sink
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (backpressure_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
            end
        end
    end

    // Ends the run when neither channel has moved a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_waypoint_bearing_steering failed");
        $finish;
    end

    initial begin : stimulus
        logic [GAIN_W-1:0]  phase_gain[NUM_PHASES];
        logic [LIMIT_W-1:0] phase_limit[NUM_PHASES];
        int                 phase, n;

        // Gain and limit per phase: both at zero, both at the top of their
        // fields (the limit beyond the output range, so the clamp fires), the
        // exact output range, a tiny gain, and two random settings.
        phase_gain[0]  = 16'd0;
        phase_limit[0] = 15'd0;
        phase_gain[1]  = 16'hFFFF;
        phase_limit[1] = 15'h7FFF;
        phase_gain[2]  = 16'd4096;
        phase_limit[2] = 15'd25736;
        phase_gain[3]  = GAIN_W'($urandom_range(65535));
        phase_limit[3] = LIMIT_W'($urandom_range(32767));
        phase_gain[4]  = 16'd1;
        phase_limit[4] = 15'd25736;
        phase_gain[5]  = GAIN_W'($urandom_range(65535));
        phase_limit[5] = LIMIT_W'($urandom_range(32767));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats under the reset values of gain and limit.
        // Coincident points: at the origin, at the corner of the range and at an ordinary point.
        offer_item('0, '0, '0, '0, '0);
        offer_item(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, HDG_W'(HDG_FULL));
        offer_item(100, -200, 100, -200, 16'hFFFF);
        // Waypoint straight east, north, west and south of the car.
        offer_item('0, '0, 1000, '0, '0);
        offer_item('0, '0, '0, 1000, 11520);
        offer_item('0, '0, -1000, '0, 23040);
        offer_item('0, '0, '0, -1000, 34560);
        offer_item(5, 5, 4, 5, 5760);
        // Longest possible vectors across the diagonals.
        offer_item(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 5760);
        offer_item(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'hFFFF);
        offer_item(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, '0);
        offer_item(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 40000);
        // Just below the east axis: the bearing rounds up to a full turn and wraps to zero.
        offer_item('0, '0, COORD_MAX, -1, '0);
        offer_item('0, '0, COORD_MIN, 1, 30000);
        offer_item('0, '0, 1, 1, 5760);
        offer_item('0, '0, -1, -1, 28800);
        // Heading of 180 degrees against bearing zero gives an error of exactly pi.
        offer_item('0, '0, 10, '0, 23040);
        // Heading zero against a westward bearing gives an error near minus pi.
        offer_item('0, '0, -10, '0, '0);
        // Zero error with a nonzero bearing: counted as a left turn.
        offer_item('0, '0, '0, 50, 11520);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            program_steering(phase_gain[phase], phase_limit[phase]);
            if (phase < 2) begin
                send_idle_pct = 6;
                recv_idle_pct = 55;
            end else if (phase < 4) begin
                send_idle_pct = 55;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // With nobody idling, stall the result side for a long stretch
            // early in the phase while beats keep coming.
            if (phase == 4)
                backpressure_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                offer_random_item();
        end

        wait_idle();
        repeat (PIPE_LATENCY + 10) @(posedge aclk);
        if (fail_count == 0 && in_flight == 0) begin
            $display("tb_waypoint_bearing_steering passed");
        end else begin
            $display("tb_waypoint_bearing_steering failed");
        end
        $finish;
    end

endmodule
